// ----- src/alqr_pkg.sv -----
// shared widths, register codes and mixer constants for the attitude lqr mixer
`default_nettype none

package alqr_pkg;

    localparam int NUM_AXES  = 3;
    localparam int NUM_MOTORS = 4;

    localparam int ANG_W   = 17;   // q8.8 degrees
    localparam int RATE_W  = 16;   // 1/16 deg/s
    localparam int GAIN_W  = 16;   // q8.8 gains, q0.16 step time
    localparam int LIM_W   = 15;   // q7.8 integral clamp
    localparam int ERR_W   = ANG_W + 1;
    localparam int SUM_W   = 24;   // integral, units of 2^-16 deg*s
    localparam int INT_W   = 28;   // integral plus increment before clamp
    localparam int MUL_A_W = 25;   // signed operand of the shared multiplier
    localparam int PROD_W  = MUL_A_W + GAIN_W + 1;
    localparam int ACC_W   = 49;   // motor accumulators, units of 2^-24 us
    localparam int FRAC_W  = 24;
    localparam int OUT_W   = 11;

    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;

    localparam int PWM_CENTER = 1500;
    localparam int PWM_MIN    = 1000;
    localparam int PWM_MAX    = 2000;

    localparam logic [1:0] AXIS_ROLL = 2'd0;
    localparam logic [1:0] AXIS_YAW  = 2'd2;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGLE_GAIN_RP = 3'd0,
        REG_ANGLE_GAIN_YAW = 3'd1,
        REG_RATE_GAIN_RP  = 3'd2,
        REG_RATE_GAIN_YAW = 3'd3,
        REG_INT_GAIN_RP   = 3'd4,
        REG_INT_GAIN_YAW  = 3'd5,
        REG_INT_LIMIT     = 3'd6,
        REG_STEP_TIME     = 3'd7
    } cfg_reg_t;

    localparam logic [GAIN_W-1:0] RST_ANGLE_GAIN_RP  = 16'd1245;
    localparam logic [GAIN_W-1:0] RST_ANGLE_GAIN_YAW = 16'd803;
    localparam logic [GAIN_W-1:0] RST_RATE_GAIN_RP   = 16'd174;
    localparam logic [GAIN_W-1:0] RST_RATE_GAIN_YAW  = 16'd309;
    localparam logic [GAIN_W-1:0] RST_INT_GAIN_RP    = 16'd4434;
    localparam logic [GAIN_W-1:0] RST_INT_GAIN_YAW   = 16'd991;
    localparam logic [LIM_W-1:0]  RST_INT_LIMIT      = 15'd12800;
    localparam logic [GAIN_W-1:0] RST_STEP_TIME      = 16'd655;

    // per motor: bit a set means the axis-a gain product is subtracted
    // (roll in bit 0), else it is added; torque is the negated product sum
    localparam logic [NUM_AXES-1:0] MIX_SUB [NUM_MOTORS] =
        '{3'b000, 3'b110, 3'b011, 3'b101};

    localparam logic signed [ACC_W-1:0] CENTER_FX = ACC_W'(PWM_CENTER) <<< FRAC_W;
    localparam logic signed [ACC_W-1:0] PWM_LO_FX = ACC_W'(PWM_MIN) <<< FRAC_W;
    localparam logic signed [ACC_W-1:0] PWM_HI_FX = ACC_W'(PWM_MAX) <<< FRAC_W;
    localparam logic signed [ACC_W-1:0] HALF_FX   = ACC_W'(1) <<< (FRAC_W - 1);

endpackage

`default_nettype wire

// ----- src/attitude_lqr_integral_mixer.sv -----
// attitude lqr controller with error integrals and x-frame quad mixer, top level
//
//  channel  dir  handshake             payload
//  s_       in   s_tvalid / s_tready   s_tdata: targets, angles, rates (one tick)
//  m_       out  m_tvalid / m_tready   m_tdata: four motor pulse widths
//  cfg_     in   cfg_valid / cfg_ready cfg_index, cfg_data (register write)
//
// each tick runs 7 sequencer steps per axis on the single shared 25x17 multiplier,
// plus one finish step and the accept in the idle state. reset (aresetn low,
// synchronous) restores register defaults and clears the integrals. a stalled
// result holds in the output register; the next tick is accepted meanwhile and
// waits in the finish step until the output is free.
`default_nettype none

module attitude_lqr_integral_mixer
    import alqr_pkg::*;
(
    input  wire                    aclk,
    input  wire                    aresetn,
    // roll_target, pitch_target, yaw_target, roll_angle, pitch_angle, yaw_angle,
    // roll_rate, pitch_rate, yaw_rate, zero pad
    input  wire  [IN_DATA_W-1:0]   s_tdata,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    // motor_one_width, motor_two_width, motor_three_width, motor_four_width, zero pad
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire  [CFG_IDX_W-1:0]   cfg_index,
    input  wire  [GAIN_W-1:0]      cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INT_MUL,     // error times step time
        ST_INT_ADD,     // round increment, add to integral
        ST_INT_CLAMP,   // clamp integral to the limit
        ST_ANG_MUL,     // angle times angle gain
        ST_RATE_MUL,    // rate times rate gain, accumulate angle term
        ST_INTEG_MUL,   // integral times integral gain, accumulate rate term
        ST_INTEG_ACC,   // accumulate integral term, next axis
        ST_FINISH       // clamp and round into the output register
    } state_t;

    // configuration registers
    logic [GAIN_W-1:0] angle_gain_rp_reg, angle_gain_yaw_reg;
    logic [GAIN_W-1:0] rate_gain_rp_reg, rate_gain_yaw_reg;
    logic [GAIN_W-1:0] int_gain_rp_reg, int_gain_yaw_reg;
    logic [LIM_W-1:0]  int_limit_reg;
    logic [GAIN_W-1:0] step_time_reg;

    state_t            state_reg, state_next;
    logic [1:0]        axis_reg, axis_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic signed [ANG_W-1:0]  angle_reg [NUM_AXES];
    logic signed [ANG_W-1:0]  angle_next [NUM_AXES];
    logic signed [RATE_W-1:0] rate_reg [NUM_AXES];
    logic signed [RATE_W-1:0] rate_next [NUM_AXES];
    logic signed [ERR_W-1:0]  err_reg [NUM_AXES];
    logic signed [ERR_W-1:0]  err_next [NUM_AXES];
    logic signed [SUM_W-1:0]  sum_reg [NUM_AXES];
    logic signed [SUM_W-1:0]  sum_next [NUM_AXES];
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [INT_W-1:0]  int_acc_reg, int_acc_next;
    logic signed [ACC_W-1:0]  motor_acc_reg [NUM_MOTORS];
    logic signed [ACC_W-1:0]  motor_acc_next [NUM_MOTORS];
    logic [OUT_W-1:0]         width_reg [NUM_MOTORS];
    logic [OUT_W-1:0]         width_next [NUM_MOTORS];

    // shared multiplier operands
    logic signed [MUL_A_W-1:0] mul_a;
    logic [GAIN_W-1:0]         mul_b;
    logic [GAIN_W-1:0]         gain_angle, gain_rate, gain_int;
    logic signed [PROD_W-1:0]  prod_rnd;
    logic signed [INT_W-1:0]   int_inc;
    logic signed [INT_W-1:0]   lim_pos;
    logic signed [ACC_W-1:0]   term;
    logic                      acc_en;
    logic signed [ACC_W-1:0]   clip [NUM_MOTORS];
    logic signed [ACC_W-1:0]   rounded [NUM_MOTORS];
    logic                      out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {4'b0, width_reg[3], width_reg[2], width_reg[1], width_reg[0]};
    assign out_free  = !m_tvalid_reg || m_tready;

    // yaw has its own gain set, roll and pitch share one
    assign gain_angle = (axis_reg == AXIS_YAW) ? angle_gain_yaw_reg : angle_gain_rp_reg;
    assign gain_rate  = (axis_reg == AXIS_YAW) ? rate_gain_yaw_reg  : rate_gain_rp_reg;
    assign gain_int   = (axis_reg == AXIS_YAW) ? int_gain_yaw_reg   : int_gain_rp_reg;

    assign lim_pos = $signed({5'b0, int_limit_reg, 8'b0});

    // operand select for the one multiplier
    always_comb begin
        unique case (state_reg)
            ST_INT_MUL: begin
                mul_a = MUL_A_W'(err_reg[axis_reg]);
                mul_b = step_time_reg;
            end
            ST_ANG_MUL: begin
                mul_a = MUL_A_W'(angle_reg[axis_reg]);
                mul_b = gain_angle;
            end
            ST_RATE_MUL: begin
                mul_a = MUL_A_W'(rate_reg[axis_reg]);
                mul_b = gain_rate;
            end
            ST_INTEG_MUL: begin
                mul_a = MUL_A_W'(sum_reg[axis_reg]);
                mul_b = gain_int;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // round half away from zero on the 8-bit drop: floor((p + 127 or 128) / 256)
    assign prod_rnd = prod_reg + (prod_reg[PROD_W-1] ? PROD_W'(127) : PROD_W'(128));
    assign int_inc  = INT_W'(prod_rnd >>> 8);

    // the product left in prod_reg, scaled to 2^-24 units
    always_comb begin
        acc_en = 1'b1;
        unique case (state_reg)
            ST_RATE_MUL:  term = ACC_W'(prod_reg) <<< 8;
            ST_INTEG_MUL: term = ACC_W'(prod_reg) <<< 12;
            ST_INTEG_ACC: term = ACC_W'(prod_reg);
            default: begin
                term   = '0;
                acc_en = 1'b0;
            end
        endcase
    end

    // motor clamp and rounding, one per motor
    always_comb begin
        for (int m = 0; m < NUM_MOTORS; m++) begin
            if (motor_acc_reg[m] < PWM_LO_FX) begin
                clip[m] = PWM_LO_FX;
            end else if (motor_acc_reg[m] > PWM_HI_FX) begin
                clip[m] = PWM_HI_FX;
            end else begin
                clip[m] = motor_acc_reg[m];
            end
            rounded[m] = clip[m] + HALF_FX;
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        axis_next     = axis_reg;
        m_tvalid_next = m_tvalid_reg;
        prod_next     = PROD_W'(mul_a * $signed({1'b0, mul_b}));
        int_acc_next  = int_acc_reg;
        angle_next    = angle_reg;
        rate_next     = rate_reg;
        err_next      = err_reg;
        sum_next      = sum_reg;
        width_next    = width_reg;
        for (int m = 0; m < NUM_MOTORS; m++) begin
            if (acc_en && MIX_SUB[m][axis_reg]) begin
                motor_acc_next[m] = motor_acc_reg[m] - term;
            end else if (acc_en) begin
                motor_acc_next[m] = motor_acc_reg[m] + term;
            end else begin
                motor_acc_next[m] = motor_acc_reg[m];
            end
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    // unpack the transaction and form the angle errors
                    for (int a = 0; a < NUM_AXES; a++) begin
                        angle_next[a] = $signed(s_tdata[(NUM_AXES + a) * ANG_W +: ANG_W]);
                        rate_next[a]  = $signed(s_tdata[2 * NUM_AXES * ANG_W + a * RATE_W
                                                        +: RATE_W]);
                        err_next[a]   = ERR_W'($signed(s_tdata[a * ANG_W +: ANG_W]))
                                      - ERR_W'($signed(s_tdata[(NUM_AXES + a) * ANG_W
                                                               +: ANG_W]));
                    end
                    for (int m = 0; m < NUM_MOTORS; m++) begin
                        motor_acc_next[m] = CENTER_FX;
                    end
                    axis_next  = AXIS_ROLL;
                    state_next = ST_INT_MUL;
                end
            end
            ST_INT_MUL: begin
                state_next = ST_INT_ADD;
            end
            ST_INT_ADD: begin
                int_acc_next = INT_W'(sum_reg[axis_reg]) + int_inc;
                state_next   = ST_INT_CLAMP;
            end
            ST_INT_CLAMP: begin
                // a limit lowered since the last tick takes hold here too
                if (int_acc_reg > lim_pos) begin
                    sum_next[axis_reg] = SUM_W'(lim_pos);
                end else if (int_acc_reg < -lim_pos) begin
                    sum_next[axis_reg] = SUM_W'(-lim_pos);
                end else begin
                    sum_next[axis_reg] = SUM_W'(int_acc_reg);
                end
                state_next = ST_ANG_MUL;
            end
            ST_ANG_MUL: begin
                state_next = ST_RATE_MUL;
            end
            ST_RATE_MUL: begin
                state_next = ST_INTEG_MUL;
            end
            ST_INTEG_MUL: begin
                state_next = ST_INTEG_ACC;
            end
            ST_INTEG_ACC: begin
                if (axis_reg == AXIS_YAW) begin
                    state_next = ST_FINISH;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_INT_MUL;
                end
            end
            ST_FINISH: begin
                // hold here while the previous result is still unclaimed
                if (out_free) begin
                    for (int m = 0; m < NUM_MOTORS; m++) begin
                        width_next[m] = rounded[m][FRAC_W +: OUT_W];
                    end
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            axis_reg           <= AXIS_ROLL;
            m_tvalid_reg       <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++) begin
                sum_reg[a] <= '0;
            end
            angle_gain_rp_reg  <= RST_ANGLE_GAIN_RP;
            angle_gain_yaw_reg <= RST_ANGLE_GAIN_YAW;
            rate_gain_rp_reg   <= RST_RATE_GAIN_RP;
            rate_gain_yaw_reg  <= RST_RATE_GAIN_YAW;
            int_gain_rp_reg    <= RST_INT_GAIN_RP;
            int_gain_yaw_reg   <= RST_INT_GAIN_YAW;
            int_limit_reg      <= RST_INT_LIMIT;
            step_time_reg      <= RST_STEP_TIME;
        end else begin
            state_reg    <= state_next;
            axis_reg     <= axis_next;
            m_tvalid_reg <= m_tvalid_next;
            sum_reg      <= sum_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_ANGLE_GAIN_RP:  angle_gain_rp_reg  <= cfg_data;
                    REG_ANGLE_GAIN_YAW: angle_gain_yaw_reg <= cfg_data;
                    REG_RATE_GAIN_RP:   rate_gain_rp_reg   <= cfg_data;
                    REG_RATE_GAIN_YAW:  rate_gain_yaw_reg  <= cfg_data;
                    REG_INT_GAIN_RP:    int_gain_rp_reg    <= cfg_data;
                    REG_INT_GAIN_YAW:   int_gain_yaw_reg   <= cfg_data;
                    REG_INT_LIMIT:      int_limit_reg      <= cfg_data[LIM_W-1:0];
                    REG_STEP_TIME:      step_time_reg      <= cfg_data;
                    default: ;
                endcase
            end
        end
        // datapath, no reset
        prod_reg      <= prod_next;
        int_acc_reg   <= int_acc_next;
        angle_reg     <= angle_next;
        rate_reg      <= rate_next;
        err_reg       <= err_next;
        motor_acc_reg <= motor_acc_next;
        width_reg     <= width_next;
    end

`ifndef SYNTH
    // the integral just clamped lies inside the limit
    a_sum_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ANG_MUL |->
            (INT_W'(sum_reg[axis_reg]) <= lim_pos) && (INT_W'(sum_reg[axis_reg]) >= -lim_pos))
        else $error("integral outside its limit after clamp");

    // a transaction starts the sequencer, the block is busy next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && state_reg == ST_INT_MUL && axis_reg == AXIS_ROLL)
        else $error("sequencer did not start on accept");

    // a new result only appears from the finish step
    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !$past(m_tvalid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish step");

    // every delivered width lies in the motor range
    a_width_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            (width_reg[0] >= OUT_W'(PWM_MIN)) && (width_reg[0] <= OUT_W'(PWM_MAX)) &&
            (width_reg[1] >= OUT_W'(PWM_MIN)) && (width_reg[1] <= OUT_W'(PWM_MAX)) &&
            (width_reg[2] >= OUT_W'(PWM_MIN)) && (width_reg[2] <= OUT_W'(PWM_MAX)) &&
            (width_reg[3] >= OUT_W'(PWM_MIN)) && (width_reg[3] <= OUT_W'(PWM_MAX)))
        else $error("motor width out of range");
`endif

endmodule

`default_nettype wire
